/* design/gsl_pkg.sv */
// ---------------------------------------------------------------------------
// gsl_pkg
// Shared types and constants of the grid square locator: store sizes, field
// widths, register indexes, status codes and the pipeline stage map.
// ---------------------------------------------------------------------------
package gsl_pkg;

  // store sizes
  localparam int GRID_CELLS  = 65536;
  localparam int MAX_SQUARES = 4096;
  localparam int CELL_AW     = $clog2(GRID_CELLS);
  localparam int ENT_AW      = $clog2(MAX_SQUARES);
  localparam int ENT_W       = ENT_AW + 1;
  localparam int GRID_W      = CELL_AW + 1;

  // field widths
  localparam int LON_W  = 29;
  localparam int LAT_W  = 28;
  localparam int CNT_W  = 9;
  localparam int SQ_W   = 2 * CNT_W;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 12;
  localparam int CFG_W  = LON_W;

  // divider: one quotient bit per stage plus an overflow stage
  localparam int QW     = CNT_W;
  localparam int DIV_N  = QW + 1;
  localparam int DVX_W  = LON_W + QW;
  localparam int DVY_W  = LAT_W + QW;

  // stage map after the divider
  localparam int ST_MUL  = DIV_N + 1;
  localparam int ST_SQ   = ST_MUL + 1;
  localparam int ST_MAP  = ST_SQ + 1;
  localparam int ST_EDGE = ST_MAP + 1;
  localparam int ST_SEL  = ST_EDGE + 1;
  localparam int NSTG    = ST_SEL + 1;

  // neighbour slots
  localparam int NB_SELF = 0;
  localparam int NB_E    = 1;
  localparam int NB_N    = 2;
  localparam int NB_W    = 3;
  localparam int NB_S    = 4;
  localparam int NB_NUM  = 5;

  typedef enum logic [2:0] {
    REG_AREA_WEST  = 3'd0,
    REG_AREA_EAST  = 3'd1,
    REG_AREA_SOUTH = 3'd2,
    REG_AREA_NORTH = 3'd3,
    REG_STEP_LON   = 3'd4,
    REG_STEP_LAT   = 3'd5,
    REG_COLUMNS    = 3'd6,
    REG_ROWS       = 3'd7
  } cfg_reg_t;

  localparam logic       ACT_LOAD   = 1'b0;
  localparam logic       ACT_SEARCH = 1'b1;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_AREA  = 2'd1;
  localparam logic [1:0] ST_OFF   = 2'd2;

  // one transaction as it travels down the pipeline
  typedef struct packed {
    logic                     search;
    logic                     load_ok;
    logic [ENT_AW-1:0]        ent;
    logic [CELL_AW-1:0]       cell_idx;
    logic [LON_W-1:0]         sq_west;
    logic [LON_W-1:0]         sq_east;
    logic [LAT_W-1:0]         sq_south;
    logic [LAT_W-1:0]         sq_north;
    logic signed [LON_W-1:0]  lon;
    logic signed [LAT_W-1:0]  lat;
    logic                     off;
  } item_t;

endpackage

/* design/grid_square_locator.sv */
// ---------------------------------------------------------------------------
// grid_square_locator
// Throughput: one transaction per cycle unless out_ready holds the pipeline;
// the divider gives one quotient bit per stage and every table lookup has its
// own read port and store copy.
// Reset: synchronous; afterwards a sweep over every cell clears the cell map,
// in_ready stays low during it while configuration writes are still taken.
// Loads update the cell map and edge stores and give no result.
// ---------------------------------------------------------------------------
module grid_square_locator
  import gsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [CELL_W-1:0]        in_cell_req,
  input  logic signed [LON_W-1:0]  in_sq_west,
  input  logic signed [LON_W-1:0]  in_sq_east,
  input  logic signed [LAT_W-1:0]  in_sq_south,
  input  logic signed [LAT_W-1:0]  in_sq_north,
  input  logic signed [LON_W-1:0]  in_longitude,
  input  logic signed [LAT_W-1:0]  in_latitude,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [CELL_W-1:0]        out_square,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  // configuration registers
  logic signed [LON_W-1:0] area_west_r, area_east_r;
  logic signed [LAT_W-1:0] area_south_r, area_north_r;
  logic [LON_W-1:0]        step_lon_r;
  logic [LAT_W-1:0]        step_lat_r;
  logic [CNT_W-1:0]        columns_r, rows_r;
  logic [GRID_W-1:0]       grid_r;
  logic [SQ_W-1:0]         grid_prod;

  // control
  logic                    pipe_en;
  logic                    clr_active_r;
  logic [CELL_AW-1:0]      clr_addr_r;
  logic [NSTG-1:0]         vld_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [CELL_W-1:0]       out_square_r;

  // entry and divider stages
  item_t                   it_r   [DIV_N+1];
  logic [LON_W-1:0]        remx_r [DIV_N+1];
  logic [LAT_W-1:0]        remy_r [DIV_N+1];
  logic [QW-1:0]           qx_r   [DIV_N+1];
  logic [QW-1:0]           qy_r   [DIV_N+1];
  logic signed [LON_W:0]   dlon;
  logic signed [LAT_W:0]   dlat;
  logic                    outside;

  // later stages
  item_t                   it_mul_r, it_sq_r, it_map_r, it_edge_r, it_sel_r;
  item_t                   it_mul_nxt, it_sq_nxt;
  logic [SQ_W-1:0]         prod_r;
  logic [CNT_W-1:0]        yc_r;
  logic [QW-1:0]           qx_f, qy_f, xc, yc;
  logic                    over;
  logic [SQ_W-1:0]         sq;
  logic [CELL_AW-1:0]      addr_r  [NB_NUM];
  logic [CELL_AW-1:0]      addr2_r [NB_NUM];
  logic [CELL_AW-1:0]      addr3_r [NB_NUM];
  logic [NB_NUM-1:0]       nbok_r, nbok2_r, nbok3_r;
  logic [ENT_W-1:0]        ent_r   [NB_NUM];
  logic [ENT_AW-1:0]       eidx    [NB_NUM];
  logic [NB_NUM-1:0]       entok_r;
  logic [2*LON_W-1:0]      lone_r  [NB_NUM];
  logic [2*LAT_W-1:0]      late_r  [NB_NUM];
  logic signed [LON_W-1:0] ew [NB_NUM], ee [NB_NUM];
  logic signed [LAT_W-1:0] es [NB_NUM], en_n [NB_NUM];
  logic [NB_NUM-1:0]       sel, sel_r;
  logic [CELL_AW-1:0]      res_cell, res_cell_r;
  logic                    res_ok, res_ok_r;
  logic [2*LON_W-1:0]      res_lon, res_lon_r;
  logic [2*LAT_W-1:0]      res_lat, res_lat_r;

  // memory write ports
  logic                    map_we, edge_we;
  logic [CELL_AW-1:0]      map_wa;
  logic [ENT_W-1:0]        map_wd;

  // handshake
  assign pipe_en   = !out_valid_r || out_ready;
  assign in_ready  = pipe_en && !clr_active_r;
  assign cfg_ready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_square = out_square_r;

  // configuration writes; a zero step is kept as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_west_r  <= '0;
      area_east_r  <= '0;
      area_south_r <= '0;
      area_north_r <= '0;
      step_lon_r   <= LON_W'(1);
      step_lat_r   <= LAT_W'(1);
      columns_r    <= CNT_W'(1);
      rows_r       <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AREA_WEST:  area_west_r  <= cfg_wdata[LON_W-1:0];
        REG_AREA_EAST:  area_east_r  <= cfg_wdata[LON_W-1:0];
        REG_AREA_SOUTH: area_south_r <= cfg_wdata[LAT_W-1:0];
        REG_AREA_NORTH: area_north_r <= cfg_wdata[LAT_W-1:0];
        REG_STEP_LON:   step_lon_r   <= (cfg_wdata[LON_W-1:0] == '0) ?
                                        LON_W'(1) : cfg_wdata[LON_W-1:0];
        REG_STEP_LAT:   step_lat_r   <= (cfg_wdata[LAT_W-1:0] == '0) ?
                                        LAT_W'(1) : cfg_wdata[LAT_W-1:0];
        REG_COLUMNS:    columns_r    <= cfg_wdata[CNT_W-1:0];
        REG_ROWS:       rows_r       <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // grid size, capped at the cell map depth
  assign grid_prod = SQ_W'(columns_r) * SQ_W'(rows_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_W'(1);
    end else if (32'(grid_prod) > GRID_CELLS) begin
      grid_r <= GRID_W'(GRID_CELLS);
    end else begin
      grid_r <= GRID_W'(grid_prod);
    end
  end

  // cell map clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + CELL_AW'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid && in_ready};
      out_valid_r <= vld_r[ST_SEL] && it_sel_r.search;
    end
  end

  // entry stage: area test and offsets from the area corner
  assign dlon = {in_longitude[LON_W-1], in_longitude} - {area_west_r[LON_W-1], area_west_r};
  assign dlat = {in_latitude[LAT_W-1], in_latitude} - {area_south_r[LAT_W-1], area_south_r};
  assign outside = (in_longitude > area_east_r) || (in_latitude > area_north_r) ||
                   (in_longitude < area_west_r) || (in_latitude < area_south_r) ||
                   (columns_r == '0) || (rows_r == '0);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_r[0].search   <= (in_action == ACT_SEARCH);
      it_r[0].load_ok  <= (32'(in_cell_req) < GRID_CELLS) &&
                          (32'(in_entry_index) < MAX_SQUARES);
      it_r[0].ent      <= in_entry_index[ENT_AW-1:0];
      it_r[0].cell_idx <= in_cell_req[CELL_AW-1:0];
      it_r[0].sq_west  <= in_sq_west;
      it_r[0].sq_east  <= in_sq_east;
      it_r[0].sq_south <= in_sq_south;
      it_r[0].sq_north <= in_sq_north;
      it_r[0].lon      <= in_longitude;
      it_r[0].lat      <= in_latitude;
      it_r[0].off      <= outside;
      remx_r[0]        <= dlon[LON_W-1:0];
      remy_r[0]        <= dlat[LAT_W-1:0];
      qx_r[0]          <= '0;
      qy_r[0]          <= '0;
    end
  end

  // restoring divider: overflow stage, then one quotient bit per stage
  for (genvar j = 0; j <= QW; j++) begin : g_div
    localparam int SH = QW - j;
    logic [DVX_W-1:0] dvx;
    logic [DVY_W-1:0] dvy;
    logic             gex, gey;

    assign dvx = DVX_W'(step_lon_r) << SH;
    assign dvy = DVY_W'(step_lat_r) << SH;
    assign gex = DVX_W'(remx_r[j]) >= dvx;
    assign gey = DVY_W'(remy_r[j]) >= dvy;

    if (j == 0) begin : g_ovf
      item_t it_nxt;

      // a quotient past the count width is past any column count
      always_comb begin
        it_nxt     = it_r[j];
        it_nxt.off = it_r[j].off || gex || gey;
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          it_r[j+1]   <= it_nxt;
          remx_r[j+1] <= remx_r[j];
          remy_r[j+1] <= remy_r[j];
          qx_r[j+1]   <= qx_r[j];
          qy_r[j+1]   <= qy_r[j];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          it_r[j+1]   <= it_r[j];
          remx_r[j+1] <= gex ? remx_r[j] - dvx[LON_W-1:0] : remx_r[j];
          remy_r[j+1] <= gey ? remy_r[j] - dvy[LAT_W-1:0] : remy_r[j];
          qx_r[j+1]   <= {qx_r[j][QW-2:0], gex};
          qy_r[j+1]   <= {qy_r[j][QW-2:0], gey};
        end
      end
    end
  end

  // clamp column and row, start the cell product
  assign qx_f = qx_r[DIV_N];
  assign qy_f = qy_r[DIV_N];
  assign over = (qx_f > columns_r) || (qy_f > rows_r);
  assign xc   = (qx_f >= columns_r) ? columns_r - CNT_W'(1) : qx_f;
  assign yc   = (qy_f >= rows_r) ? rows_r - CNT_W'(1) : qy_f;

  always_comb begin
    it_mul_nxt     = it_r[DIV_N];
    it_mul_nxt.off = it_r[DIV_N].off || over;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_mul_r <= it_mul_nxt;
      prod_r   <= SQ_W'(xc) * SQ_W'(rows_r);
      yc_r     <= yc;
    end
  end

  // cell index and its four neighbours (east +rows, north +1)
  assign sq = prod_r + SQ_W'(yc_r);

  always_comb begin
    it_sq_nxt     = it_mul_r;
    it_sq_nxt.off = it_mul_r.off || (sq >= SQ_W'(grid_r));
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_sq_r         <= it_sq_nxt;
      addr_r[NB_SELF] <= sq[CELL_AW-1:0];
      addr_r[NB_E]    <= CELL_AW'(sq + SQ_W'(rows_r));
      addr_r[NB_N]    <= CELL_AW'(sq + SQ_W'(1));
      addr_r[NB_W]    <= CELL_AW'(sq - SQ_W'(rows_r));
      addr_r[NB_S]    <= CELL_AW'(sq - SQ_W'(1));
      nbok_r[NB_SELF] <= 1'b1;
      nbok_r[NB_E]    <= (sq + SQ_W'(rows_r)) < SQ_W'(grid_r);
      nbok_r[NB_N]    <= (sq + SQ_W'(1)) < SQ_W'(grid_r);
      nbok_r[NB_W]    <= sq >= SQ_W'(rows_r);
      nbok_r[NB_S]    <= sq != '0;
    end
  end

  // cell map: one copy per lookup, loads and the sweep write every copy
  assign map_we = clr_active_r ||
                  (pipe_en && vld_r[ST_SQ] && !it_sq_r.search && it_sq_r.load_ok);
  assign map_wa = clr_active_r ? clr_addr_r : it_sq_r.cell_idx;
  assign map_wd = clr_active_r ? '0 : ENT_W'(it_sq_r.ent) + ENT_W'(1);

  for (genvar k = 0; k < NB_NUM; k++) begin : g_map
    logic [ENT_W-1:0] mem [GRID_CELLS];
    always_ff @(posedge clk) begin
      if (map_we) begin
        mem[map_wa] <= map_wd;
      end
      if (pipe_en) begin
        ent_r[k] <= mem[addr_r[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_map_r <= it_sq_r;
      addr2_r  <= addr_r;
      nbok2_r  <= nbok_r;
    end
  end

  // edge stores: one copy per lookup, written by loads
  assign edge_we = pipe_en && vld_r[ST_MAP] && !it_map_r.search && it_map_r.load_ok;

  for (genvar k = 0; k < NB_NUM; k++) begin : g_edge
    logic [2*LON_W-1:0] lon_mem [MAX_SQUARES];
    logic [2*LAT_W-1:0] lat_mem [MAX_SQUARES];

    assign eidx[k] = ENT_AW'(ent_r[k] - ENT_W'(1));

    always_ff @(posedge clk) begin
      if (edge_we) begin
        lon_mem[it_map_r.ent] <= {it_map_r.sq_east, it_map_r.sq_west};
        lat_mem[it_map_r.ent] <= {it_map_r.sq_north, it_map_r.sq_south};
      end
      if (pipe_en) begin
        lone_r[k]  <= lon_mem[eidx[k]];
        late_r[k]  <= lat_mem[eidx[k]];
        entok_r[k] <= (ent_r[k] != '0) && (ent_r[k] <= ENT_W'(MAX_SQUARES));
      end
    end

    assign ew[k]   = lone_r[k][LON_W-1:0];
    assign ee[k]   = lone_r[k][2*LON_W-1:LON_W];
    assign es[k]   = late_r[k][LAT_W-1:0];
    assign en_n[k] = late_r[k][2*LAT_W-1:LAT_W];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_edge_r <= it_map_r;
      addr3_r   <= addr2_r;
      nbok3_r   <= nbok2_r;
    end
  end

  // nudge toward one neighbour, using own edges or the neighbours' edges
  always_comb begin
    sel = '0;
    if (entok_r[NB_SELF]) begin
      priority if (it_edge_r.lon > ee[NB_SELF] && nbok3_r[NB_E]) begin
        sel[NB_E] = 1'b1;
      end else if (it_edge_r.lat > en_n[NB_SELF] && nbok3_r[NB_N]) begin
        sel[NB_N] = 1'b1;
      end else if (it_edge_r.lon < ew[NB_SELF] && nbok3_r[NB_W]) begin
        sel[NB_W] = 1'b1;
      end else if (it_edge_r.lat < es[NB_SELF] && nbok3_r[NB_S]) begin
        sel[NB_S] = 1'b1;
      end else begin
        sel[NB_SELF] = 1'b1;
      end
    end else begin
      priority if (nbok3_r[NB_E] && entok_r[NB_E] && it_edge_r.lon > ew[NB_E]) begin
        sel[NB_E] = 1'b1;
      end else if (nbok3_r[NB_N] && entok_r[NB_N] && it_edge_r.lat > es[NB_N]) begin
        sel[NB_N] = 1'b1;
      end else if (nbok3_r[NB_W] && entok_r[NB_W] && it_edge_r.lon < ee[NB_W]) begin
        sel[NB_W] = 1'b1;
      end else if (nbok3_r[NB_S] && entok_r[NB_S] && it_edge_r.lat < en_n[NB_S]) begin
        sel[NB_S] = 1'b1;
      end else begin
        sel[NB_SELF] = 1'b1;
      end
    end
  end

  // pick the chosen cell with its entry and edges
  always_comb begin
    res_cell = '0;
    res_ok   = 1'b0;
    res_lon  = '0;
    res_lat  = '0;
    for (int k = 0; k < NB_NUM; k++) begin
      res_cell = res_cell | (addr3_r[k] & {CELL_AW{sel[k]}});
      res_ok   = res_ok | (entok_r[k] & sel[k]);
      res_lon  = res_lon | (lone_r[k] & {(2*LON_W){sel[k]}});
      res_lat  = res_lat | (late_r[k] & {(2*LAT_W){sel[k]}});
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_sel_r   <= it_edge_r;
      sel_r      <= sel;
      res_cell_r <= res_cell;
      res_ok_r   <= res_ok;
      res_lon_r  <= res_lon;
      res_lat_r  <= res_lat;
    end
  end

  // containment test into the output register
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      priority if (it_sel_r.off) begin
        out_status_r <= ST_OFF;
        out_square_r <= '0;
      end else if (!res_ok_r ||
                   $signed(res_lon_r[LON_W-1:0]) > it_sel_r.lon ||
                   $signed(res_lon_r[2*LON_W-1:LON_W]) < it_sel_r.lon ||
                   $signed(res_lat_r[LAT_W-1:0]) > it_sel_r.lat ||
                   $signed(res_lat_r[2*LAT_W-1:LAT_W]) < it_sel_r.lat) begin
        out_status_r <= ST_AREA;
        out_square_r <= '0;
      end else begin
        out_status_r <= ST_FOUND;
        out_square_r <= CELL_W'(res_cell_r);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // reset always starts the clearing sweep
  a_clr_start: assert property (@(posedge clk) !rst_n |=> clr_active_r)
    else $error("clearing sweep not started by reset");

  // no transaction is in flight while the map is being cleared
  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (vld_r == '0))
    else $error("transaction in flight during clearing sweep");

  // exactly one neighbour slot is chosen for a search
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_SEL] && it_sel_r.search) |-> $onehot(sel_r))
    else $error("neighbour selection not one-hot");

  // a cell is reported only with a hit
  a_square_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_FOUND) |-> (out_square_r == '0))
    else $error("square reported without a hit");
`endif

endmodule

/* sim/gsl_checker.sv */
// ---------------------------------------------------------------------------
// gsl_checker
// Scoreboard of the grid square locator: it mirrors the registers, the cell
// map and the edge stores and predicts each search from them. Every result
// transaction is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsl_checker
  import gsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_action,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic [CELL_W-1:0]       in_cell_req,
  input  logic signed [LON_W-1:0] in_sq_west,
  input  logic signed [LON_W-1:0] in_sq_east,
  input  logic signed [LAT_W-1:0] in_sq_south,
  input  logic signed [LAT_W-1:0] in_sq_north,
  input  logic signed [LON_W-1:0] in_longitude,
  input  logic signed [LAT_W-1:0] in_latitude,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              out_status,
  input  logic [CELL_W-1:0]       out_square,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic [1:0]        status;
    logic [CELL_W-1:0] square;
  } answer_t;

  answer_t answers_due[$];

  // mirrored registers
  logic signed [LON_W-1:0] a_west, a_east;
  logic signed [LAT_W-1:0] a_south, a_north;
  logic [LON_W-1:0]        stp_lon;
  logic [LAT_W-1:0]        stp_lat;
  logic [CNT_W-1:0]        n_cols, n_rows;

  // mirrored stores
  logic [ENT_W-1:0]        cell_owner [GRID_CELLS];
  logic signed [LON_W-1:0] edge_w [MAX_SQUARES];
  logic signed [LON_W-1:0] edge_e [MAX_SQUARES];
  logic signed [LAT_W-1:0] edge_s [MAX_SQUARES];
  logic signed [LAT_W-1:0] edge_n [MAX_SQUARES];

  assign outstanding = answers_due.size();

  // entry held by a cell, -1 when empty or outside the map
  function automatic longint owner_of(longint c);
    longint e;
    if (c < 0 || c >= GRID_CELLS) return -1;
    e = cell_owner[c];
    if (e == 0 || e > MAX_SQUARES) return -1;
    return e - 1;
  endfunction

  // cell after the neighbour nudge, -1 for off map
  function automatic longint nudged_cell(longint lon, longint lat);
    longint w, e, s, n, sl, st, nc, nr, grid, x, y, sq, idx, nb, r;
    w = a_west; e = a_east; s = a_south; n = a_north;
    sl = (stp_lon == 0) ? 1 : stp_lon;
    st = (stp_lat == 0) ? 1 : stp_lat;
    nc = n_cols; nr = n_rows;
    if (nc == 0 || nr == 0) return -1;
    grid = nc * nr;
    if (grid > GRID_CELLS) grid = GRID_CELLS;
    if (lon > e || lat > n || lon < w || lat < s) return -1;
    x = (lon - w) / sl;
    y = (lat - s) / st;
    if (x > nc || y > nr) return -1;
    if (x >= nc) x = nc - 1;
    if (y >= nr) y = nr - 1;
    sq = x * nr + y;
    if (sq >= grid) return -1;
    idx = owner_of(sq);
    if (idx >= 0) begin
      if (lon > edge_e[idx] && sq + nr < grid) return sq + nr;
      if (lat > edge_n[idx] && sq + 1 < grid) return sq + 1;
      if (lon < edge_w[idx] && sq - nr >= 0) return sq - nr;
      if (lat < edge_s[idx] && sq - 1 >= 0) return sq - 1;
      return sq;
    end
    // empty cell: look for a neighbour that reaches over
    nb = sq + nr;
    if (nb < grid) begin
      r = owner_of(nb);
      if (r >= 0 && lon > edge_w[r]) return nb;
    end
    nb = sq + 1;
    if (nb < grid) begin
      r = owner_of(nb);
      if (r >= 0 && lat > edge_s[r]) return nb;
    end
    nb = sq - nr;
    if (nb >= 0) begin
      r = owner_of(nb);
      if (r >= 0 && lon < edge_e[r]) return nb;
    end
    nb = sq - 1;
    if (nb >= 0) begin
      r = owner_of(nb);
      if (r >= 0 && lat < edge_n[r]) return nb;
    end
    return sq;
  endfunction

  function automatic answer_t locate_point(longint lon, longint lat);
    answer_t a;
    longint  sq, idx;
    a.status = ST_OFF;
    a.square = '0;
    sq = nudged_cell(lon, lat);
    if (sq < 0) return a;
    a.status = ST_AREA;
    idx = owner_of(sq);
    if (idx < 0) return a;
    if (edge_w[idx] > lon || edge_e[idx] < lon || edge_s[idx] > lat || edge_n[idx] < lat)
      return a;
    a.status = ST_FOUND;
    a.square = sq[CELL_W-1:0];
    return a;
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    answer_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      a_west <= '0; a_east <= '0; a_south <= '0; a_north <= '0;
      stp_lon <= LON_W'(1); stp_lat <= LAT_W'(1); n_cols <= CNT_W'(1); n_rows <= CNT_W'(1);
      for (int i = 0; i < GRID_CELLS; i++) cell_owner[i] = '0;
      answers_due.delete();
      fail_count <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_AREA_WEST:  a_west  <= cfg_wdata[LON_W-1:0];
          REG_AREA_EAST:  a_east  <= cfg_wdata[LON_W-1:0];
          REG_AREA_SOUTH: a_south <= cfg_wdata[LAT_W-1:0];
          REG_AREA_NORTH: a_north <= cfg_wdata[LAT_W-1:0];
          REG_STEP_LON:   stp_lon <= cfg_wdata[LON_W-1:0];
          REG_STEP_LAT:   stp_lat <= cfg_wdata[LAT_W-1:0];
          REG_COLUMNS:    n_cols  <= cfg_wdata[CNT_W-1:0];
          REG_ROWS:       n_rows  <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result with no prediction: status %0d square %0d", out_status, out_square);
          errs++;
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_square !== want.square) begin
            $error("square: expected %0d, actual %0d", want.square, out_square);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      // input transaction: load or search
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD) begin
          if (in_cell_req < GRID_CELLS && in_entry_index < MAX_SQUARES) begin
            cell_owner[in_cell_req] = ENT_W'(in_entry_index) + ENT_W'(1);
            edge_w[in_entry_index] = in_sq_west;
            edge_e[in_entry_index] = in_sq_east;
            edge_s[in_entry_index] = in_sq_south;
            edge_n[in_entry_index] = in_sq_north;
          end
        end else begin
          answers_due.push_back(locate_point(in_longitude, in_latitude));
        end
      end
    end
  end

endmodule

/* sim/grid_square_locator_tb.sv */
// ---------------------------------------------------------------------------
// grid_square_locator_tb
// Drives loads and searches over a series of grid settings with directed
// corner points first, then random squares and points, under several
// sender and receiver idle patterns; the checker scores every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_square_locator_tb;
  import gsl_pkg::*;

  localparam int HANG_LIMIT = 400000;
  localparam int DRAIN_WAIT = 40;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 85;
  localparam longint LON_MAX = 180000000;
  localparam longint LAT_MAX = 90000000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_action;
  logic [IDX_W-1:0]        in_entry_index;
  logic [CELL_W-1:0]       in_cell_req;
  logic signed [LON_W-1:0] in_sq_west, in_sq_east, in_longitude;
  logic signed [LAT_W-1:0] in_sq_south, in_sq_north, in_latitude;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_status;
  logic [CELL_W-1:0]       out_square;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [2:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  int                      fail_count;
  int                      outstanding;
  int                      send_idle_pct;
  int                      recv_stall_pct;
  int                      quiet_cycles;

  // current grid setting, used to aim the stimulus
  longint g_west, g_east, g_south, g_north, g_slon, g_slat, g_cols, g_rows;

  grid_square_locator dut (.*);

  gsl_checker u_checker (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint rnd(longint lo, longint hi);
    if (hi <= lo) return lo;
    return lo + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF) % (hi - lo + 1);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic send_item(logic act, longint ent, longint cell_no, longint sw, longint se,
                           longint ss, longint sn, longint lon, longint lat);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= ent[IDX_W-1:0];
    in_cell_req    <= cell_no[CELL_W-1:0];
    in_sq_west     <= sw[LON_W-1:0];
    in_sq_east     <= se[LON_W-1:0];
    in_sq_south    <= ss[LAT_W-1:0];
    in_sq_north    <= sn[LAT_W-1:0];
    in_longitude   <= lon[LON_W-1:0];
    in_latitude    <= lat[LAT_W-1:0];
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic load_square(longint ent, longint cell_no, longint sw, longint se,
                             longint ss, longint sn);
    send_item(ACT_LOAD, ent, cell_no, sw, se, ss, sn, rnd(-LON_MAX, LON_MAX),
              rnd(-LAT_MAX, LAT_MAX));
  endtask

  task automatic search_point(longint lon, longint lat);
    send_item(ACT_SEARCH, rnd(0, 4095), rnd(0, 65535), rnd(-LON_MAX, LON_MAX),
              rnd(-LON_MAX, LON_MAX), rnd(-LAT_MAX, LAT_MAX), rnd(-LAT_MAX, LAT_MAX),
              lon, lat);
  endtask

  // wait out every result and the pipeline tail behind trailing loads
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_grid(longint w, longint e, longint s, longint n, longint slon,
                            longint slat, longint nc, longint nr);
    longint vals [8];
    vals = '{w, e, s, n, slon, slat, nc, nr};
    g_west = w; g_east = e; g_south = s; g_north = n;
    g_slon = slon; g_slat = slat; g_cols = nc; g_rows = nr;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= vals[i][CFG_W-1:0];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    cfg_valid <= 1'b0;
  endtask

  // random grid that fits inside the world
  task automatic pick_grid(int phase);
    longint nc, nr, sl, st, w, s;
    case (phase % 4)
      0: begin nc = rnd(1, 8);   nr = rnd(1, 8);   end
      1: begin nc = rnd(1, 256); nr = rnd(1, 16);  end
      2: begin nc = rnd(1, 16);  nr = rnd(1, 256); end
      default: begin nc = rnd(1, 32); nr = rnd(1, 32); end
    endcase
    sl = rnd(1, (2 * LON_MAX) / (nc + 2));
    st = rnd(1, (2 * LAT_MAX) / (nr + 2));
    w = rnd(-LON_MAX, LON_MAX - (nc + 2) * sl);
    s = rnd(-LAT_MAX, LAT_MAX - (nr + 2) * st);
    write_grid(w, w + nc * sl - 1 + rnd(0, 2 * sl), s, s + nr * st - 1 + rnd(0, 2 * st),
               sl, st, nc, nr);
  endtask

  // square matching a grid cell, edges nudged at random
  task automatic load_for_cell(longint cell_no);
    longint x, y, w, s, jl, jt;
    x = cell_no / g_rows;
    y = cell_no % g_rows;
    w = g_west + x * g_slon;
    s = g_south + y * g_slat;
    jl = g_slon / 4;
    jt = g_slat / 4;
    load_square(rnd(0, 4095), cell_no,
                clampl(w + rnd(-jl, jl), -LON_MAX, LON_MAX),
                clampl(w + g_slon - 1 + rnd(-jl, jl), -LON_MAX, LON_MAX),
                clampl(s + rnd(-jt, jt), -LAT_MAX, LAT_MAX),
                clampl(s + g_slat - 1 + rnd(-jt, jt), -LAT_MAX, LAT_MAX));
  endtask

  task automatic random_phase();
    longint grid;
    int     pick;
    grid = g_cols * g_rows;
    if (grid > GRID_CELLS) grid = GRID_CELLS;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)
        load_for_cell(rnd(0, grid - 1));
      else if (pick < 42)
        load_square(rnd(0, 4095), rnd(0, 65535), rnd(-LON_MAX, LON_MAX),
                    rnd(-LON_MAX, LON_MAX), rnd(-LAT_MAX, LAT_MAX), rnd(-LAT_MAX, LAT_MAX));
      else if (pick < 92)
        search_point(clampl(rnd(g_west - g_slon, g_east + g_slon), -LON_MAX, LON_MAX),
                     clampl(rnd(g_south - g_slat, g_north + g_slat), -LAT_MAX, LAT_MAX));
      else
        search_point(rnd(-LON_MAX, LON_MAX), rnd(-LAT_MAX, LAT_MAX));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_LOAD;
    in_entry_index = '0;
    in_cell_req = '0;
    in_sq_west = '0; in_sq_east = '0; in_sq_south = '0; in_sq_north = '0;
    in_longitude = '0; in_latitude = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    g_west = 0; g_east = 0; g_south = 0; g_north = 0;
    g_slon = 1; g_slat = 1; g_cols = 1; g_rows = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset setting is a single cell at the origin
    search_point(0, 0);
    search_point(1, 0);
    search_point(-1, 0);
    search_point(0, -1);
    load_square(0, 0, 0, 0, 0, 0);
    search_point(0, 0);
    load_square(4095, 65535, -LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    search_point(LON_MAX, LAT_MAX);
    load_square(4095, 0, -LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    search_point(0, 0);
    // sender holds off until every result is back
    drain();

    // directed: whole world as one cell with the widest steps
    write_grid(-LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX, 2 * LON_MAX, 2 * LAT_MAX, 1, 1);
    search_point(-LON_MAX, -LAT_MAX);
    search_point(LON_MAX, LAT_MAX);
    search_point(0, 0);
    drain();

    // directed: largest grid over the whole world
    write_grid(-LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX, 1406250, 703125, 256, 256);
    load_for_cell(65535);
    load_for_cell(0);
    load_for_cell(256);
    load_for_cell(1);
    search_point(LON_MAX, LAT_MAX);
    search_point(-LON_MAX, -LAT_MAX);
    search_point(-LON_MAX + 1406250, -LAT_MAX + 10);
    search_point(-LON_MAX + 5, -LAT_MAX + 703125);
    search_point(-LON_MAX + 1406249 + 200000, -LAT_MAX + 5);
    drain();

    // random phases under the idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      pick_grid(p);
      random_phase();
      drain();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/gsl_pkg.sv
design/grid_square_locator.sv
sim/gsl_checker.sv
sim/grid_square_locator_tb.sv
